>>> hw/rtl/ssc_pkg.sv
// Shared types, constants and the history counter update for the sample stability classifier.
package ssc_pkg;

   localparam int LINE_WIDTH      = 4;
   localparam int SLOT_WIDTH      = 13;
   localparam int BYTE_WIDTH      = 8;
   localparam int COLOR_WIDTH     = 6;
   localparam int TOTAL_WIDTH     = 24;
   localparam int LEVEL_WIDTH     = 8;
   localparam int HIST_WIDTH      = 2 * LEVEL_WIDTH;
   localparam int MASK_WIDTH      = 2;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_POLARITY = 1'b0;

   localparam logic [LEVEL_WIDTH-1:0] MID_LEVEL  = 8'h80;
   localparam logic [LEVEL_WIDTH-1:0] FULL_LEVEL = 8'hff;

   localparam logic [COLOR_WIDTH-1:0] COL_NONE    = 6'b000000;
   localparam logic [COLOR_WIDTH-1:0] COL_FRAME   = 6'b000001;
   localparam logic [COLOR_WIDTH-1:0] COL_ERROR   = 6'b110000;
   localparam logic [COLOR_WIDTH-1:0] COL_FLICKER = 6'b111010;
   localparam logic [COLOR_WIDTH-1:0] COL_STABLE  = 6'b001000;
   localparam logic [COLOR_WIDTH-1:0] COL_HIT     = 6'b001100;

   // Outcome of classifying one sample: color and the per-frame count increments.
   typedef struct packed {
      logic [COLOR_WIDTH-1:0] color;
      logic [1:0]             hits;
      logic [1:0]             flickers;
   } ssc_class_type;

   // An on channel climbs toward full and never sits below the middle level;
   // an off channel decays toward zero and never sits above it.
   function automatic logic [LEVEL_WIDTH-1:0] track_level(input logic [LEVEL_WIDTH-1:0] g,
                                                          input logic on);
      logic [LEVEL_WIDTH-1:0] r;
      r = g;
      if (on) begin
         if (r != FULL_LEVEL) r = r + 1'b1;
         if (r < MID_LEVEL) r = MID_LEVEL;
      end else begin
         if (r != '0) r = r - 1'b1;
         if (r > MID_LEVEL) r = MID_LEVEL;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/ssc_addr_map.sv
// Maps a line number and slot offset onto a history memory address.
module ssc_addr_map #(
   parameter int LINES          = 16,
   parameter int SLOTS_PER_LINE = 8192,
   parameter int ADDR_WIDTH     = 17
) (
   input  logic [ssc_pkg::LINE_WIDTH-1:0] line_number,
   input  logic [ssc_pkg::SLOT_WIDTH-1:0] slot_offset,
   output logic [ADDR_WIDTH-1:0]          addr
);
   import ssc_pkg::*;

   logic [LINE_WIDTH-1:0] line_mod;
   logic [SLOT_WIDTH-1:0] slot_mod;

   // Remainders by restoring subtraction of the shifted constant divisor.
   always_comb begin
      line_mod = line_number;
      for (int j = LINE_WIDTH; j >= 0; j--) begin
         if (32'(line_mod) >= (LINES << j)) begin
            line_mod = line_mod - LINE_WIDTH'(LINES << j);
         end
      end
   end

   always_comb begin
      slot_mod = slot_offset;
      for (int j = 5; j >= 0; j--) begin
         if (32'(slot_mod) >= (SLOTS_PER_LINE << j)) begin
            slot_mod = slot_mod - SLOT_WIDTH'(SLOTS_PER_LINE << j);
         end
      end
   end

   assign addr = ADDR_WIDTH'(32'(line_mod) * SLOTS_PER_LINE + 32'(slot_mod));

endmodule

>>> hw/rtl/ssc_history.sv
// History memory with one read and one write port and a zeroing sweep after reset.
module ssc_history #(
   parameter int DEPTH      = 131072,
   parameter int ADDR_WIDTH = 17
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [ADDR_WIDTH-1:0]           rd_addr,
   output logic [ssc_pkg::HIST_WIDTH-1:0]  rd_data,
   input  logic                            wr_en,
   input  logic [ADDR_WIDTH-1:0]           wr_addr,
   input  logic [ssc_pkg::HIST_WIDTH-1:0]  wr_data,
   output logic                            clearing
);
   import ssc_pkg::*;

   logic [HIST_WIDTH-1:0] history_mem [DEPTH];
   logic [HIST_WIDTH-1:0] rd_data_ff;
   logic [ADDR_WIDTH-1:0] clr_ptr_ff, clr_ptr_in;
   logic                  clearing_ff, clearing_in;

   always_comb begin
      clr_ptr_in  = clr_ptr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         if (clr_ptr_ff == ADDR_WIDTH'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_ptr_in = clr_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ptr_ff  <= clr_ptr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         history_mem[clr_ptr_ff] <= '0;
      end else if (wr_en) begin
         history_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= history_mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

>>> hw/rtl/ssc_update.sv
// Updates both channel counters of one slot and classifies the sample.
module ssc_update (
   input  logic [ssc_pkg::HIST_WIDTH-1:0]  hist_old,
   input  logic [ssc_pkg::MASK_WIDTH-1:0]  bits,
   input  logic                            pixel_point,
   output logic [ssc_pkg::HIST_WIDTH-1:0]  hist_new,
   output ssc_pkg::ssc_class_type          result
);
   import ssc_pkg::*;

   logic [LEVEL_WIDTH-1:0] g1, g2;

   assign g1       = track_level(hist_old[LEVEL_WIDTH-1:0], bits[0]);
   assign g2       = track_level(hist_old[HIST_WIDTH-1:LEVEL_WIDTH], bits[1]);
   assign hist_new = {g2, g1};

   // Channel 1 is judged first; channel 2 overrides the color when it is not off.
   always_comb begin
      result.color    = pixel_point ? COL_FRAME : COL_NONE;
      result.hits     = '0;
      result.flickers = '0;
      if (g1 == FULL_LEVEL) begin
         result.color = pixel_point ? COL_HIT : COL_STABLE;
         result.hits  = result.hits + 2'(pixel_point);
      end else if (g1 != '0) begin
         result.color    = pixel_point ? COL_ERROR : COL_FLICKER;
         result.flickers = result.flickers + 2'(pixel_point);
      end
      if (g2 == FULL_LEVEL) begin
         result.color = pixel_point ? COL_HIT : COL_STABLE;
         result.hits  = result.hits + 2'(pixel_point);
      end else if (g2 != '0) begin
         result.color    = pixel_point ? COL_ERROR : COL_FLICKER;
         result.flickers = result.flickers + 2'(pixel_point);
      end
   end

endmodule

>>> hw/rtl/sample_stability_classifier.sv
// Top level of the sample stability classifier: pipeline control, counters and register port.
module sample_stability_classifier #(
   parameter int LINES          = 16,
   parameter int SLOTS_PER_LINE = 8192,
   parameter int COUNT_WIDTH    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ssc_pkg::LINE_WIDTH-1:0]      req_line_number,
   input  logic [ssc_pkg::SLOT_WIDTH-1:0]      req_slot_offset,
   input  logic [ssc_pkg::BYTE_WIDTH-1:0]      req_sample_byte,
   input  logic                                req_odd_half,
   input  logic                                req_pixel_point,
   input  logic                                req_new_frame,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ssc_pkg::COLOR_WIDTH-1:0]     rsp_display_color,
   output logic [ssc_pkg::TOTAL_WIDTH-1:0]     rsp_hit_total,
   output logic [ssc_pkg::TOTAL_WIDTH-1:0]     rsp_flicker_total,
   // Register port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ssc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ssc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ssc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   // This block takes one video sample per cycle, unless the result channel stalls or the
   // history memory is being zeroed, and returns one result per sample. Each sample reads
   // its history slot from a single-port-read, single-port-write memory in the cycle it is
   // accepted; the update stage then updates both channel counters, writes them back,
   // classifies the sample and moves the result into the output register, from which it
   // transfers while rsp_stall is low. A sample that follows another sample to the same slot
   // gets the fresh counters through a forwarding path, so the sustained rate stays at one
   // sample per cycle while nothing stalls. The read-modify-write of the history memory is
   // what sets this rate. After reset the block zeroes all LINES*SLOTS_PER_LINE entries of
   // the history memory (131072 with the default sizes), one entry per cycle; req_stall stays
   // high during that sweep, while the polarity register can already be written. The
   // polarity register lies at byte address 0 and its two bits invert the two channel bits
   // of the sample. Hit and flicker totals saturate and restart on a sample that flags a new
   // frame; they are reported on the low 24 bits.
   import ssc_pkg::*;

   localparam int DEPTH      = LINES * SLOTS_PER_LINE;
   localparam int ADDR_WIDTH = $clog2(DEPTH);

   // Polarity register.
   logic [MASK_WIDTH-1:0]      polarity_ff, polarity_in;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                       csr_write;

   // Acceptance and read stage.
   logic                  req_accept;
   logic                  clearing;
   logic [ADDR_WIDTH-1:0] req_addr;
   logic [MASK_WIDTH-1:0] req_bits;

   // Update stage.
   logic                  upd_valid_ff, upd_valid_in;
   logic [ADDR_WIDTH-1:0] upd_addr_ff;
   logic [MASK_WIDTH-1:0] upd_bits_ff;
   logic                  upd_pix_ff;
   logic                  upd_nf_ff;
   logic                  fwd_ff, fwd_in;
   logic [HIST_WIDTH-1:0] fwd_data_ff;
   logic [HIST_WIDTH-1:0] mem_rd_data;
   logic [HIST_WIDTH-1:0] hist_old, hist_new;
   ssc_class_type         upd_result;
   logic                  upd_advance;

   // Output stage and frame counters.
   logic                   out_valid_ff, out_valid_in;
   logic [COLOR_WIDTH-1:0] out_color_ff;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_WIDTH-1:0] flk_cnt_ff, flk_cnt_in;
   logic [COUNT_WIDTH-1:0] hit_base, flk_base;
   logic [COUNT_WIDTH:0]   hit_sum, flk_sum;

   // ---------------------------------------------------------------- register port
   // The port never waits; a write lands on the edge that completes the access cycle.
   // Addresses that match no register read as zero and ignore writes.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      polarity_in = polarity_ff;
      if (csr_write && (csr_index == REG_POLARITY)) begin
         polarity_in = csr_pwdata[MASK_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_POLARITY) begin
         csr_prdata = CSR_DATA_WIDTH'(polarity_ff);
      end
   end

   // ---------------------------------------------------------------- accept and read
   // The update stage may take a new sample when it is empty or hands its sample on in
   // the same cycle; nothing enters while the history memory is still being zeroed.
   assign upd_advance = upd_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = clearing || (upd_valid_ff && !upd_advance);
   assign req_accept  = req_valid && !req_stall;

   ssc_addr_map #(
      .LINES          (LINES),
      .SLOTS_PER_LINE (SLOTS_PER_LINE),
      .ADDR_WIDTH     (ADDR_WIDTH)
   ) u_addr_map (
      .line_number (req_line_number),
      .slot_offset (req_slot_offset),
      .addr        (req_addr)
   );

   // Even half uses bits 5 and 6, odd half bits 1 and 2; channel 1 is the lower bit.
   assign req_bits = (req_odd_half ? req_sample_byte[2:1] : req_sample_byte[6:5]) ^ polarity_ff;

   ssc_history #(
      .DEPTH      (DEPTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_addr),
      .rd_data  (mem_rd_data),
      .wr_en    (upd_advance),
      .wr_addr  (upd_addr_ff),
      .wr_data  (hist_new),
      .clearing (clearing)
   );

   // A read issued on the same edge as the write to that slot returns the old contents,
   // so the value being written is captured and used in its place.
   assign fwd_in       = upd_advance && (req_addr == upd_addr_ff);
   assign upd_valid_in = req_accept || (upd_valid_ff && !upd_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         upd_valid_ff <= upd_valid_in;
         if (req_accept) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         upd_addr_ff <= req_addr;
         upd_bits_ff <= req_bits;
         upd_pix_ff  <= req_pixel_point;
         upd_nf_ff   <= req_new_frame;
         fwd_data_ff <= hist_new;
      end
   end

   // ---------------------------------------------------------------- update stage
   assign hist_old = fwd_ff ? fwd_data_ff : mem_rd_data;

   ssc_update u_update (
      .hist_old    (hist_old),
      .bits        (upd_bits_ff),
      .pixel_point (upd_pix_ff),
      .hist_new    (hist_new),
      .result      (upd_result)
   );

   // Counters restart before the sample that opens a frame and stop at all ones.
   assign hit_base = upd_nf_ff ? '0 : hit_cnt_ff;
   assign flk_base = upd_nf_ff ? '0 : flk_cnt_ff;
   assign hit_sum  = {1'b0, hit_base} + (COUNT_WIDTH + 1)'(upd_result.hits);
   assign flk_sum  = {1'b0, flk_base} + (COUNT_WIDTH + 1)'(upd_result.flickers);

   always_comb begin
      hit_cnt_in = hit_cnt_ff;
      flk_cnt_in = flk_cnt_ff;
      if (upd_advance) begin
         hit_cnt_in = hit_sum[COUNT_WIDTH] ? '1 : hit_sum[COUNT_WIDTH-1:0];
         flk_cnt_in = flk_sum[COUNT_WIDTH] ? '1 : flk_sum[COUNT_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------- output stage
   // The counters only move when a result enters the output register, so they double as
   // the totals of the result on display.
   assign out_valid_in = upd_advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff  <= '0;
         out_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         flk_cnt_ff   <= '0;
      end else begin
         polarity_ff  <= polarity_in;
         out_valid_ff <= out_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         flk_cnt_ff   <= flk_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_advance) begin
         out_color_ff <= upd_result.color;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_display_color = out_color_ff;
   assign rsp_hit_total     = TOTAL_WIDTH'({{TOTAL_WIDTH{1'b0}}, hit_cnt_ff});
   assign rsp_flicker_total = TOTAL_WIDTH'({{TOTAL_WIDTH{1'b0}}, flk_cnt_ff});

`ifndef NO_ASSERTIONS
   // No sample may enter while the history memory is still being zeroed.
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("sample accepted during history clearing");

   // A sample held by a stalled output keeps its slot address until it moves on.
   a_update_holds: assert property (@(posedge clock) disable iff (reset)
      (upd_valid_ff && !upd_advance) |=> (upd_valid_ff && $stable(upd_addr_ff)))
      else $error("update stage lost or changed a waiting sample");

   // A back-to-back sample on the same slot must take the forwarded counters.
   a_forward_same_slot: assert property (@(posedge clock) disable iff (reset)
      (req_accept && upd_advance && (req_addr == upd_addr_ff)) |=> fwd_ff)
      else $error("same-slot sample missed the forwarding path");

   // Within a frame the hit total never goes down.
   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      (upd_advance && !upd_nf_ff) |=> (hit_cnt_ff >= $past(hit_cnt_ff)))
      else $error("hit total decreased within a frame");
`endif

endmodule
